### rtl/rgd_pkg.sv
// Types and constants shared by the RDS group decoder.
`timescale 1ns / 1ps

package rgd_pkg;

    localparam int STATION_CHARS = 8;
    localparam int TEXT_CHARS    = 64;
    localparam int STATION_SEGS  = STATION_CHARS / 2;
    localparam int TEXT_SEGS     = TEXT_CHARS / 4;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 48;

    // Command carried in tuser of the input stream.
    typedef enum logic [1:0] {
        FUNC_GROUP = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_CLEAR = 2'd3
    } t_func;

    // Group type and version, bits 15..11 of block B.
    localparam logic [4:0] GT_0A = 5'b00000;
    localparam logic [4:0] GT_0B = 5'b00001;
    localparam logic [4:0] GT_2A = 5'b00100;
    localparam logic [4:0] GT_4A = 5'b01000;

    localparam logic [7:0] CHAR_CR = 8'h0D;

    localparam logic [6:0] TEXT_LEN_MAX = 7'(TEXT_CHARS);

endpackage

### rtl/rds_group_decoder.sv
// RDS group decoder: station name, RadioText, clock time and running clock.
`timescale 1ns / 1ps

// One beat enters per clock and every input beat produces exactly one output beat: the
// beat is held in an input register, decoded in one pass of logic against the stored
// text and clock state, and the result lands in an output register. The rate is one
// beat per clock, set by that single decode pass; back-pressure on the output stalls
// the input register and nothing is lost. The input beat carries the command in tuser
// (0 group, 1 one-second tick, 2 read a snapshot character, 3 clear text state). Every
// output beat reports the snapshot status and the running clock; the character fields are
// only non-zero for a read. Station name and RadioText are kept as two-character and
// four-character segments in flip-flops, so a snapshot copies in the same clock.
module rds_group_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // block_b [15:0], block_c [31:16], block_d [47:32], char_index [53:48], zeros [55:54]
    input  logic [55:0] s_axis_tdata,
    // func [1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // station_ready [0], text_len [7:1], time_valid [8], hours [13:9], minutes [20:14],
    // seconds [26:21], station_char [34:27], text_char [42:35], zeros [47:43]
    output logic [47:0] m_axis_tdata
);
    import rgd_pkg::*;

    // Input register
    logic                  r_in_valid;
    t_func                 r_func;
    logic [15:0]           r_block_b;
    logic [15:0]           r_block_c;
    logic [15:0]           r_block_d;
    logic [5:0]            r_char_index;

    // Output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;

    // Decoder state
    logic [15:0]           r_station_work [STATION_SEGS];
    logic [15:0]           n_station_work [STATION_SEGS];
    logic [15:0]           r_station_snap [STATION_SEGS];
    logic [15:0]           n_station_snap [STATION_SEGS];
    logic [STATION_SEGS-1:0] r_station_mask, n_station_mask;
    logic                  r_station_full, n_station_full;
    logic [31:0]           r_text_work [TEXT_SEGS];
    logic [31:0]           n_text_work [TEXT_SEGS];
    logic [31:0]           r_text_snap [TEXT_SEGS];
    logic [31:0]           n_text_snap [TEXT_SEGS];
    logic [TEXT_SEGS-1:0]  r_text_mask, n_text_mask;
    logic [6:0]            r_text_work_len, n_text_work_len;
    logic [6:0]            r_text_snap_len, n_text_snap_len;
    logic [4:0]            r_clk_hours, n_clk_hours;
    logic [6:0]            r_clk_minutes, n_clk_minutes;
    logic [5:0]            r_clk_seconds, n_clk_seconds;
    logic                  r_clk_valid, n_clk_valid;

    // Decode temporaries
    logic                  advance;
    logic [4:0]            group_type;
    logic [1:0]            st_seg;
    logic [STATION_SEGS-1:0] st_bit;
    logic [STATION_SEGS-1:0] st_mask;
    logic [3:0]            tx_seg;
    logic [TEXT_SEGS-1:0]  tx_bit;
    logic [TEXT_SEGS-1:0]  tx_mask;
    logic [31:0]           tx_word;
    logic                  cr_found;
    logic [1:0]            cr_pos;
    logic [6:0]            tm_min;
    logic [6:0]            tm_hour;
    logic [3:0]            tm_off;
    logic [6:0]            tk_sec;
    logic [7:0]            tk_min;
    logic [5:0]            tk_hour;
    logic [7:0]            station_char;
    logic [7:0]            text_char;
    logic [15:0]           rd_st_word;
    logic [31:0]           rd_tx_word;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign group_type = r_block_b[15:11];
    assign st_seg     = r_block_b[1:0];
    assign st_bit     = STATION_SEGS'(1) << st_seg;
    assign tx_seg     = r_block_b[3:0];
    assign tx_bit     = TEXT_SEGS'(1) << tx_seg;
    assign tx_word    = {r_block_c, r_block_d};
    assign rd_st_word = r_station_snap[r_char_index[2:1]];
    assign rd_tx_word = r_text_snap[r_char_index[5:2]];

    // Lowest character position in the segment holding a carriage return.
    always_comb begin
        cr_found = 1'b0;
        cr_pos   = 2'd0;
        for (int i = 3; i >= 0; i--) begin
            if (tx_word[31-8*i -: 8] == CHAR_CR) begin
                cr_found = 1'b1;
                cr_pos   = 2'(i);
            end
        end
    end

    always_comb begin
        n_station_work  = r_station_work;
        n_station_snap  = r_station_snap;
        n_station_mask  = r_station_mask;
        n_station_full  = r_station_full;
        n_text_work     = r_text_work;
        n_text_snap     = r_text_snap;
        n_text_mask     = r_text_mask;
        n_text_work_len = r_text_work_len;
        n_text_snap_len = r_text_snap_len;
        n_clk_hours     = r_clk_hours;
        n_clk_minutes   = r_clk_minutes;
        n_clk_seconds   = r_clk_seconds;
        n_clk_valid     = r_clk_valid;
        station_char    = 8'd0;
        text_char       = 8'd0;
        st_mask         = r_station_mask;
        tx_mask         = r_text_mask;
        tm_min          = 7'(r_block_d[11:6]);
        tm_hour         = 7'({r_block_c[0], r_block_d[15:12]});
        tm_off          = r_block_d[4:1];
        tk_sec          = 7'(r_clk_seconds) + 7'd1;
        tk_min          = 8'(r_clk_minutes);
        tk_hour         = 6'(r_clk_hours);

        unique case (r_func)
            FUNC_GROUP: begin
                if (group_type == GT_0A || group_type == GT_0B) begin
                    if (!((r_station_mask & st_bit) != '0
                          && r_station_work[st_seg] == r_block_d)) begin
                        if ((r_station_mask & st_bit) != '0) begin
                            st_mask = st_bit;
                        end else begin
                            st_mask = r_station_mask | st_bit;
                        end
                        n_station_mask         = st_mask;
                        n_station_work[st_seg] = r_block_d;
                        if (st_mask == '1) begin
                            n_station_snap = n_station_work;
                            n_station_full = 1'b1;
                        end
                    end
                end else if (group_type == GT_2A) begin
                    if (!((r_text_mask & tx_bit) != '0
                          && r_text_work[tx_seg] == tx_word)) begin
                        if ((r_text_mask & tx_bit) != '0) begin
                            n_text_work_len = TEXT_LEN_MAX;
                            tx_mask         = tx_bit;
                        end else begin
                            tx_mask = r_text_mask | tx_bit;
                        end
                        n_text_work[tx_seg] = tx_word;
                        // A carriage return ends the text: every later segment counts.
                        if (cr_found) begin
                            n_text_work_len = {1'b0, tx_seg, cr_pos};
                            tx_mask         = tx_mask | ({TEXT_SEGS{1'b1}} << tx_seg);
                        end
                        n_text_mask = tx_mask;
                        if (tx_mask == '1) begin
                            n_text_snap     = n_text_work;
                            n_text_snap_len = n_text_work_len;
                        end
                    end
                end else if (group_type == GT_4A) begin
                    // Local offset in half hours; bit 5 of block D selects west of UTC.
                    if (r_block_d[5]) begin
                        if (r_block_d[0]) begin
                            if (tm_min < 7'd30) begin
                                tm_min  = tm_min + 7'd30;
                                tm_hour = (tm_hour == 7'd0) ? 7'd23 : tm_hour - 7'd1;
                            end else begin
                                tm_min = tm_min - 7'd30;
                            end
                        end
                        if (tm_hour < 7'(tm_off)) begin
                            tm_hour = tm_hour + 7'd24 - 7'(tm_off);
                        end else begin
                            tm_hour = tm_hour - 7'(tm_off);
                        end
                    end else begin
                        if (r_block_d[0]) begin
                            if (tm_min >= 7'd30) begin
                                tm_min  = tm_min - 7'd30;
                                tm_hour = (tm_hour == 7'd23) ? 7'd0 : tm_hour + 7'd1;
                            end else begin
                                tm_min = tm_min + 7'd30;
                            end
                        end
                        if (tm_hour >= 7'd24 - 7'(tm_off)) begin
                            tm_hour = tm_hour + 7'(tm_off) - 7'd24;
                        end else begin
                            tm_hour = tm_hour + 7'(tm_off);
                        end
                    end
                    n_clk_hours   = tm_hour[4:0];
                    n_clk_minutes = tm_min;
                    n_clk_seconds = 6'd0;
                    n_clk_valid   = 1'b1;
                end
            end
            FUNC_TICK: begin
                if (tk_sec >= 7'd60) begin
                    tk_sec = tk_sec - 7'd60;
                    tk_min = tk_min + 8'd1;
                    if (tk_min >= 8'd60) begin
                        tk_min  = tk_min - 8'd60;
                        tk_hour = tk_hour + 6'd1;
                        if (tk_hour >= 6'd24) begin
                            tk_hour = tk_hour - 6'd24;
                        end
                    end
                end
                n_clk_seconds = tk_sec[5:0];
                n_clk_minutes = tk_min[6:0];
                n_clk_hours   = tk_hour[4:0];
            end
            FUNC_READ: begin
                if (r_station_full) begin
                    station_char = r_char_index[0] ? rd_st_word[7:0] : rd_st_word[15:8];
                end
                if ({1'b0, r_char_index} < r_text_snap_len) begin
                    text_char = rd_tx_word[31-8*r_char_index[1:0] -: 8];
                end
            end
            FUNC_CLEAR: begin
                // The station snapshot data is never read while the full flag is low.
                n_station_mask  = '0;
                n_station_full  = 1'b0;
                n_text_mask     = '0;
                n_text_snap_len = 7'd0;
            end
            default: begin
            end
        endcase

        n_out_data = {5'd0, text_char, station_char, n_clk_seconds, n_clk_minutes,
                      n_clk_hours, n_clk_valid, n_text_snap_len, n_station_full};
    end

    // Handshake and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_station_mask  <= '0;
            r_station_full  <= 1'b0;
            r_text_mask     <= '0;
            r_text_work_len <= TEXT_LEN_MAX;
            r_text_snap_len <= 7'd0;
            r_clk_hours     <= 5'd0;
            r_clk_minutes   <= 7'd0;
            r_clk_seconds   <= 6'd0;
            r_clk_valid     <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid     <= 1'b1;
                r_station_mask  <= n_station_mask;
                r_station_full  <= n_station_full;
                r_text_mask     <= n_text_mask;
                r_text_work_len <= n_text_work_len;
                r_text_snap_len <= n_text_snap_len;
                r_clk_hours     <= n_clk_hours;
                r_clk_minutes   <= n_clk_minutes;
                r_clk_seconds   <= n_clk_seconds;
                r_clk_valid     <= n_clk_valid;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and text storage. Work buffers start at zero, as the snapshots copy them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STATION_SEGS; i++) begin
                r_station_work[i] <= 16'd0;
                r_station_snap[i] <= 16'd0;
            end
            for (int i = 0; i < TEXT_SEGS; i++) begin
                r_text_work[i] <= 32'd0;
                r_text_snap[i] <= 32'd0;
            end
        end else if (advance) begin
            r_station_work <= n_station_work;
            r_station_snap <= n_station_snap;
            r_text_work    <= n_text_work;
            r_text_snap    <= n_text_snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_func       <= t_func'(s_axis_tuser);
            r_block_b    <= s_axis_tdata[15:0];
            r_block_c    <= s_axis_tdata[31:16];
            r_block_d    <= s_axis_tdata[47:32];
            r_char_index <= s_axis_tdata[53:48];
        end
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    a_seconds_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clk_seconds < 6'd60)
        else $error("running clock seconds out of range");

    a_text_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_text_snap_len <= TEXT_LEN_MAX && r_text_work_len <= TEXT_LEN_MAX)
        else $error("RadioText length beyond buffer");

    a_time_valid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clk_valid |=> r_clk_valid)
        else $error("time valid dropped without reset");

    a_state_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_clk_seconds) && $stable(r_text_mask)
                     && $stable(r_station_mask))
        else $error("decoder state changed without a beat");

endmodule

### tb/rgd_checker.sv
// Checker for the RDS group decoder: predicts every output beat and compares it.
`timescale 1ns / 1ps

module rgd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_tvalid,
    input  logic        i_in_tready,
    // block_b [15:0], block_c [31:16], block_d [47:32], char_index [53:48], zeros [55:54]
    input  logic [55:0] i_in_tdata,
    // func [1:0]
    input  logic [1:0]  i_in_tuser,
    input  logic        i_out_tvalid,
    input  logic        i_out_tready,
    // station_ready [0], text_len [7:1], time_valid [8], hours [13:9], minutes [20:14],
    // seconds [26:21], station_char [34:27], text_char [42:35], zeros [47:43]
    input  logic [47:0] i_out_tdata,
    output int          o_fail_count,
    output int          o_pending
);
    import rgd_pkg::*;

    typedef struct packed {
        logic [7:0] text_char;
        logic [7:0] station_char;
        logic [5:0] seconds;
        logic [6:0] minutes;
        logic [4:0] hours;
        logic       time_valid;
        logic [6:0] text_len;
        logic       station_ready;
    } t_status;

    logic [7:0]  name_work [STATION_CHARS];
    logic [7:0]  name_snap [STATION_CHARS];
    logic [3:0]  name_mask;
    logic        name_snap_full;
    logic [7:0]  text_work [TEXT_CHARS];
    logic [7:0]  text_snap [TEXT_CHARS];
    logic [15:0] text_mask;
    logic [6:0]  text_work_len;
    logic [6:0]  text_snap_len;
    logic [4:0]  run_hours;
    logic [6:0]  run_minutes;
    logic [5:0]  run_seconds;
    logic        run_valid;

    t_status     expected_status [$];
    t_status     want;
    t_status     got;
    int          out_beats;

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] seen, input logic [7:0] due);
        if (seen !== due)
            report_mismatch($sformatf("output beat %0d: %s is %0h, expected %0h",
                                      out_beats, name, seen, due));
    endtask

    task automatic clear_decoder_state();
        for (int k = 0; k < STATION_CHARS; k++) begin
            name_work[k] = '0;
            name_snap[k] = '0;
        end
        for (int k = 0; k < TEXT_CHARS; k++) begin
            text_work[k] = '0;
            text_snap[k] = '0;
        end
        name_mask      = '0;
        name_snap_full = 1'b0;
        text_mask      = '0;
        text_work_len  = TEXT_LEN_MAX;
        text_snap_len  = '0;
        run_hours      = '0;
        run_minutes    = '0;
        run_seconds    = '0;
        run_valid      = 1'b0;
    endtask

    task automatic store_name_segment(input logic [1:0] seg, input logic [7:0] ch_a, ch_b);
        int         pos;
        logic [3:0] seg_bit;
        pos     = int'(seg) * 2;
        seg_bit = 4'b0001 << seg;
        if ((name_mask & seg_bit) != 0) begin
            if (name_work[pos] == ch_a && name_work[pos + 1] == ch_b)
                return;
            name_mask = seg_bit;
        end else begin
            name_mask |= seg_bit;
        end
        name_work[pos]     = ch_a;
        name_work[pos + 1] = ch_b;
        if (name_mask == 4'hF) begin
            name_snap      = name_work;
            name_snap_full = 1'b1;
        end
    endtask

    task automatic store_text_segment(input logic [3:0] seg, input logic [7:0] chars [4]);
        int          pos;
        int          cr_pos;
        logic [15:0] seg_bit;
        logic        cr_seen;
        logic        same;
        pos     = int'(seg) * 4;
        seg_bit = 16'h0001 << seg;
        if ((text_mask & seg_bit) != 0) begin
            same = 1'b1;
            for (int k = 0; k < 4; k++)
                if (text_work[pos + k] != chars[k])
                    same = 1'b0;
            if (same)
                return;
            text_work_len = TEXT_LEN_MAX;
            text_mask     = seg_bit;
        end else begin
            text_mask |= seg_bit;
        end
        // The lowest carriage return in the segment sets the length.
        cr_seen = 1'b0;
        cr_pos  = 0;
        for (int k = 3; k >= 0; k--) begin
            text_work[pos + k] = chars[k];
            if (chars[k] == CHAR_CR) begin
                cr_seen = 1'b1;
                cr_pos  = pos + k;
            end
        end
        if (cr_seen) begin
            text_work_len = 7'(cr_pos);
            text_mask    |= ~(seg_bit - 16'd1);
        end
        if (text_mask == 16'hFFFF) begin
            text_snap     = text_work;
            text_snap_len = text_work_len;
        end
    endtask

    task automatic load_clock_time(input logic [15:0] blk_c, blk_d);
        int hrs;
        int mins;
        int offs;
        mins = int'(blk_d[11:6]);
        hrs  = int'({blk_c[0], blk_d[15:12]});
        offs = int'(blk_d[4:0]);
        if (blk_d[5]) begin
            if (offs % 2 == 1) begin
                if (mins < 30) begin
                    mins += 30;
                    hrs = (hrs == 0) ? 23 : hrs - 1;
                end else begin
                    mins -= 30;
                end
            end
            offs = offs / 2;
            if (hrs < offs)
                hrs = hrs + 24 - offs;
            else
                hrs = hrs - offs;
        end else begin
            if (offs % 2 == 1) begin
                if (mins >= 30) begin
                    mins -= 30;
                    hrs = (hrs == 23) ? 0 : hrs + 1;
                end else begin
                    mins += 30;
                end
            end
            offs = offs / 2;
            if (hrs >= 24 - offs)
                hrs = hrs - 24 + offs;
            else
                hrs = hrs + offs;
        end
        run_hours   = 5'(hrs);
        run_minutes = 7'(mins);
        run_seconds = '0;
        run_valid   = 1'b1;
    endtask

    task automatic advance_clock();
        int hrs;
        int mins;
        int secs;
        secs = int'(run_seconds) + 1;
        mins = int'(run_minutes);
        hrs  = int'(run_hours);
        if (secs >= 60) begin
            secs -= 60;
            mins += 1;
            if (mins >= 60) begin
                mins -= 60;
                hrs  += 1;
                if (hrs >= 24)
                    hrs -= 24;
            end
        end
        run_seconds = 6'(secs);
        run_minutes = 7'(mins);
        run_hours   = 5'(hrs);
    endtask

    task automatic decode_rds_command(input t_func cmd, input logic [15:0] blk_b, blk_c, blk_d,
                                      input logic [5:0] idx, output t_status st);
        logic [7:0] seg_chars [4];
        st = '0;
        case (cmd)
            FUNC_GROUP: begin
                if (blk_b[15:11] == GT_0A || blk_b[15:11] == GT_0B) begin
                    store_name_segment(blk_b[1:0], blk_d[15:8], blk_d[7:0]);
                end else if (blk_b[15:11] == GT_2A) begin
                    seg_chars = '{blk_c[15:8], blk_c[7:0], blk_d[15:8], blk_d[7:0]};
                    store_text_segment(blk_b[3:0], seg_chars);
                end else if (blk_b[15:11] == GT_4A) begin
                    load_clock_time(blk_c, blk_d);
                end
            end
            FUNC_TICK: begin
                advance_clock();
            end
            FUNC_CLEAR: begin
                name_mask      = '0;
                name_snap_full = 1'b0;
                for (int k = 0; k < STATION_CHARS; k++)
                    name_snap[k] = '0;
                text_mask      = '0;
                text_snap_len  = '0;
            end
            default: begin
                if (name_snap_full)
                    st.station_char = name_snap[idx[2:0]];
                if (idx < text_snap_len)
                    st.text_char = text_snap[idx];
            end
        endcase
        st.station_ready = name_snap_full;
        st.text_len      = text_snap_len;
        st.time_valid    = run_valid;
        st.hours         = run_hours;
        st.minutes       = run_minutes;
        st.seconds       = run_seconds;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_decoder_state();
            expected_status.delete();
            o_fail_count = 0;
            out_beats    = 0;
        end else begin
            if (i_in_tvalid && i_in_tready) begin
                decode_rds_command(t_func'(i_in_tuser), i_in_tdata[15:0], i_in_tdata[31:16],
                                   i_in_tdata[47:32], i_in_tdata[53:48], want);
                expected_status.push_back(want);
            end
            if (i_out_tvalid && i_out_tready) begin
                out_beats++;
                if (expected_status.size() == 0) begin
                    report_mismatch($sformatf("output beat %0d arrived with no command waiting",
                                              out_beats));
                end else begin
                    want = expected_status.pop_front();
                    got  = t_status'(i_out_tdata[42:0]);
                    check_field("station_ready", 8'(got.station_ready), 8'(want.station_ready));
                    check_field("text_len", 8'(got.text_len), 8'(want.text_len));
                    check_field("time_valid", 8'(got.time_valid), 8'(want.time_valid));
                    check_field("hours", 8'(got.hours), 8'(want.hours));
                    check_field("minutes", 8'(got.minutes), 8'(want.minutes));
                    check_field("seconds", 8'(got.seconds), 8'(want.seconds));
                    check_field("station_char", got.station_char, want.station_char);
                    check_field("text_char", got.text_char, want.text_char);
                    check_field("padding", 8'(i_out_tdata[47:43]), 8'd0);
                end
            end
        end
        o_pending = expected_status.size();
    end

endmodule

### tb/tb_rds_group_decoder.sv
// Testbench top for the RDS group decoder: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps

module tb_rds_group_decoder;
    import rgd_pkg::*;

    localparam int TOTAL_BEATS = 825;
    localparam int HOLD_CYCLES = 120;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = FUNC_GROUP;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    int          fail_count;
    int          pending;
    int          beats_sent    = 0;
    bit          idle_en       = 1'b1;
    bit          hold_req      = 1'b0;

    rds_group_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rgd_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #(2_000_000);
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: random back-pressure, and one long hold-off when asked for.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= !(idle_en && $urandom_range(0, 99) < 14);
            end
        end
    end

    function automatic logic [7:0] random_char();
        if ($urandom_range(0, 99) < 85)
            return 8'($urandom_range(32, 126));
        return 8'($urandom);
    endfunction

    task automatic send_cmd(input t_func cmd, input logic [15:0] blk_b, blk_c, blk_d,
                            input logic [5:0] idx);
        while (idle_en && $urandom_range(0, 99) < 14) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, idx, blk_d, blk_c, blk_b};
        s_axis_tuser  <= cmd;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        beats_sent++;
    endtask

    task automatic send_read(input logic [5:0] idx);
        send_cmd(FUNC_READ, 16'($urandom), 16'($urandom), 16'($urandom), idx);
    endtask

    task automatic shuffle_segments(input int nseg, output int order [16]);
        int j;
        int tmp;
        for (int k = 0; k < 16; k++)
            order[k] = k;
        for (int k = nseg - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
    endtask

    task automatic send_station_name();
        logic [7:0] name [STATION_CHARS];
        int         order [16];
        int         seg;
        for (int k = 0; k < STATION_CHARS; k++)
            name[k] = random_char();
        shuffle_segments(4, order);
        for (int k = 0; k < 4; k++) begin
            seg = order[k];
            // Now and then a segment arrives garbled, which restarts the mask.
            if ($urandom_range(0, 99) < 6)
                send_cmd(FUNC_GROUP, {GT_0A, 9'($urandom), 2'(seg)}, 16'($urandom),
                         16'($urandom), 6'($urandom));
            send_cmd(FUNC_GROUP, {($urandom_range(0, 1) != 0) ? GT_0B : GT_0A, 9'($urandom),
                     2'(seg)}, 16'($urandom), {name[2 * seg], name[2 * seg + 1]},
                     6'($urandom));
            if ($urandom_range(0, 99) < 15)
                send_cmd(FUNC_GROUP, {GT_0A, 9'($urandom), 2'(seg)}, 16'($urandom),
                         {name[2 * seg], name[2 * seg + 1]}, 6'($urandom));
        end
        repeat ($urandom_range(1, 3)) send_read(6'($urandom));
    endtask

    task automatic send_radio_text();
        logic [7:0] txt [TEXT_CHARS];
        int         order [16];
        int         nseg;
        int         cr_at;
        int         seg;
        for (int k = 0; k < TEXT_CHARS; k++) begin
            txt[k] = random_char();
            if (txt[k] == CHAR_CR)
                txt[k] = 8'h20;
        end
        nseg = TEXT_SEGS;
        // A carriage return makes every later segment count, so those need not be sent.
        if ($urandom_range(0, 99) < 40) begin
            cr_at      = $urandom_range(0, TEXT_CHARS - 1);
            txt[cr_at] = CHAR_CR;
            nseg       = cr_at / 4 + 1;
        end
        shuffle_segments(nseg, order);
        for (int k = 0; k < nseg; k++) begin
            seg = order[k];
            if ($urandom_range(0, 99) < 4)
                send_cmd(FUNC_GROUP, {GT_2A, 7'($urandom), 4'(seg)}, 16'($urandom),
                         16'($urandom), 6'($urandom));
            send_cmd(FUNC_GROUP, {GT_2A, 7'($urandom), 4'(seg)},
                     {txt[4 * seg], txt[4 * seg + 1]}, {txt[4 * seg + 2], txt[4 * seg + 3]},
                     6'($urandom));
        end
        repeat ($urandom_range(2, 4)) send_read(6'($urandom));
    endtask

    task automatic send_time_and_ticks();
        int         nticks;
        logic [3:0] hour_low;
        logic       hour_top;
        if ($urandom_range(0, 99) < 35) begin
            // Minute 59 and no offset: a full minute of ticks carries into the hours.
            hour_low = 4'($urandom);
            hour_top = 1'($urandom);
            if ($urandom_range(0, 1) != 0) begin
                hour_low = 4'd7;
                hour_top = 1'b1;
            end
            send_cmd(FUNC_GROUP, {GT_4A, 11'($urandom)}, {15'($urandom), hour_top},
                     {hour_low, 6'd59, 6'd0}, 6'($urandom));
            nticks = $urandom_range(60, 62);
        end else begin
            send_cmd(FUNC_GROUP, {GT_4A, 11'($urandom)}, 16'($urandom), 16'($urandom),
                     6'($urandom));
            nticks = $urandom_range(0, 5);
        end
        repeat (nticks)
            send_cmd(FUNC_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 6'($urandom));
    endtask

    task automatic run_directed();
        send_read(6'd63);
        send_cmd(FUNC_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63);
        // Out-of-range hours and minutes with the largest offsets, west then east.
        send_cmd(FUNC_GROUP, 16'h4000, 16'hFFFF, 16'hFFFF, 6'd0);
        send_cmd(FUNC_GROUP, 16'h47FF, 16'h0001, 16'hFFDF, 6'd0);
        // Midnight minus half an hour wraps to the previous day.
        send_cmd(FUNC_GROUP, 16'h4000, 16'h0000, 16'h0021, 6'd0);
        send_cmd(FUNC_TICK, 16'h0000, 16'h0000, 16'h0000, 6'd0);
        send_cmd(FUNC_GROUP, {GT_0A, 11'd0}, 16'h0000, 16'h5244, 6'd0);
        send_cmd(FUNC_GROUP, {GT_0B, 11'd1}, 16'h0000, 16'h5320, 6'd0);
        send_cmd(FUNC_GROUP, {GT_0A, 11'd2}, 16'h0000, 16'h5445, 6'd0);
        send_cmd(FUNC_GROUP, {GT_0A, 11'd3}, 16'h0000, 16'h5354, 6'd0);
        send_cmd(FUNC_GROUP, {GT_0B, 11'h7FF}, 16'hFFFF, 16'h5354, 6'd0);
        send_read(6'd13);
        send_cmd(FUNC_GROUP, {GT_0A, 11'd1}, 16'h0000, 16'h00FF, 6'd0);
        send_read(6'd7);
        send_cmd(FUNC_GROUP, {GT_2A, 11'd0}, 16'h4869, 16'h2120, 6'd0);
        send_cmd(FUNC_GROUP, {GT_2A, 11'd1}, 16'h4F4B, 16'h0D00, 6'd0);
        send_read(6'd5);
        send_read(6'd6);
        send_cmd(FUNC_GROUP, 16'h27FF, 16'hFFFF, 16'hFFFF, 6'd0);
        // Group types that the decoder ignores.
        send_cmd(FUNC_GROUP, 16'h2800, 16'h0D0D, 16'h0D0D, 6'd0);
        send_cmd(FUNC_GROUP, 16'hF800, 16'hFFFF, 16'hFFFF, 6'd0);
        send_cmd(FUNC_GROUP, 16'h4800, 16'hFFFF, 16'hFFFF, 6'd0);
        send_cmd(FUNC_CLEAR, 16'h0000, 16'h0000, 16'h0000, 6'd0);
        send_read(6'd63);
    endtask

    initial begin
        int  pick;
        int  wait_cycles;
        bit  hold_done;
        hold_done = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        while (beats_sent < TOTAL_BEATS) begin
            if (!hold_done && beats_sent >= 300) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            idle_en = !(beats_sent >= 500 && beats_sent < 650);
            pick    = $urandom_range(0, 99);
            if (pick < 20)
                send_station_name();
            else if (pick < 45)
                send_radio_text();
            else if (pick < 57)
                send_time_and_ticks();
            else if (pick < 72)
                send_read(($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, 7))
                                                     : 6'($urandom));
            else if (pick < 76)
                send_cmd(FUNC_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                         6'($urandom));
            else
                send_cmd(t_func'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                         16'($urandom), 6'($urandom));
        end
        s_axis_tvalid <= 1'b0;
        idle_en = 1'b1;
        // Let the checker count the last beat before the queue is judged.
        @(posedge i_clk);
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 2000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
rtl/rgd_pkg.sv
rtl/rds_group_decoder.sv
tb/rgd_checker.sv
tb/tb_rds_group_decoder.sv
